@@ sv/bgtr_pkg.sv @@
// Package for the bitmap glyph text renderer: shared codes, reset values,
// the configuration bundle and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package bgtr_pkg;

    // Input item kinds (carried on the slave-side tuser).
    localparam logic CMD_FONT_WRITE = 1'b0;
    localparam logic CMD_RENDER     = 1'b1;

    // Control character codes.
    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;

    // Draw command codes (carried on the master-side tuser).
    localparam logic [1:0] OP_SET_PIXEL = 2'd0;
    localparam logic [1:0] OP_FILL_BOX  = 2'd1;
    localparam logic [1:0] OP_CLEAR_BOX = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd0;
    localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd1;
    localparam logic [2:0] REG_GLYPH_BYTES  = 3'd2;
    localparam logic [2:0] REG_SCALE        = 3'd3;
    localparam logic [2:0] REG_SPACING      = 3'd4;
    localparam logic [2:0] REG_LEFT_MARGIN  = 3'd5;

    // Configuration reset values.
    localparam logic [3:0] RST_GLYPH_WIDTH  = 4'd5;
    localparam logic [4:0] RST_GLYPH_HEIGHT = 5'd7;
    localparam logic [3:0] RST_GLYPH_BYTES  = 4'd5;
    localparam logic [3:0] RST_SCALE        = 4'd1;
    localparam logic [3:0] RST_SPACING      = 4'd3;
    localparam logic [9:0] RST_LEFT_MARGIN  = 10'd0;

    // Most font bytes walked for one character.
    localparam logic [3:0] MAX_WALK_BYTES = 4'd8;

    // Coordinate limits of the output fields.
    localparam logic [13:0] X_MAX = 14'd2047;
    localparam logic [13:0] Y_MAX = 14'd4095;

    typedef struct packed {
        logic [3:0] glyph_width;
        logic [4:0] glyph_height;
        logic [3:0] glyph_bytes;
        logic [3:0] scale;
        logic [3:0] spacing;
        logic [9:0] left_margin;
    } bgtr_cfg_t;

    typedef struct packed {
        logic font_wr;
        logic newline;
        logic bs_edge;
        logic bs_box;
        logic glyph_start;
        logic reduce;
        logic rd_en;
        logic bit_step;
        logic flush;
    } bgtr_cmd_t;

    typedef struct packed {
        logic is_write;
        logic is_newline;
        logic is_bs;
        logic at_left_edge;
        logic base_ge_depth;
        logic nb_zero;
        logic bit_set;
        logic last_bit;
        logic last_byte;
        logic pend_valid;
        logic out_free;
    } bgtr_sts_t;

    function automatic logic [10:0] clamp_x(input logic [13:0] v);
        clamp_x = (v > X_MAX) ? X_MAX[10:0] : v[10:0];
    endfunction

    function automatic logic [11:0] clamp_y(input logic [13:0] v);
        clamp_y = (v > Y_MAX) ? Y_MAX[11:0] : v[11:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/bgtr_ctrl.sv @@
// Controller state machine of the bitmap glyph text renderer.
// Depends on bgtr_pkg for the command and status types.
`default_nettype none

module bgtr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire bgtr_pkg::bgtr_sts_t sts,
    output bgtr_pkg::bgtr_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (sts.is_write)
                    begin
                        cmd.font_wr = 1'b1;
                    end
                    else if (sts.is_newline)
                    begin
                        cmd.newline = 1'b1;
                    end
                    else if (sts.is_bs)
                    begin
                        if (sts.at_left_edge)
                        begin
                            cmd.bs_edge = 1'b1;
                        end
                        else
                        begin
                            cmd.bs_box = 1'b1;
                            state_next = ST_FLUSH;
                        end
                    end
                    else
                    begin
                        cmd.glyph_start = 1'b1;
                        state_next      = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                // Bring the base address into the font store range, one
                // subtraction of the depth per cycle.
                if (sts.base_ge_depth)
                begin
                    cmd.reduce = 1'b1;
                end
                else if (sts.nb_zero)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                // A set bit with a result already held must wait for room downstream.
                if (!(sts.bit_set && sts.pend_valid && !sts.out_free))
                begin
                    cmd.bit_step = 1'b1;
                    if (sts.last_bit)
                    begin
                        state_next = sts.last_byte ? ST_FLUSH : ST_READ;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!sts.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A held result is never overwritten while the output stage is full.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.bit_step && sts.bit_set && sts.pend_valid) |-> sts.out_free)
        else $error("held result would be lost");

    // Only one item is in progress at a time.
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (!in_ready && (cmd.glyph_start == 1'b0)))
        else $error("input taken while busy");

endmodule

`default_nettype wire

@@ sv/bgtr_datapath.sv @@
// Datapath of the bitmap glyph text renderer: font store, cursor, glyph walk
// counters, held result and output register. Depends on bgtr_pkg.
`default_nettype none

module bgtr_datapath #(
    parameter int LINE_LIMIT = 1024,
    parameter int FONT_DEPTH = 2048,
    parameter int START_ROW  = 58
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bgtr_pkg::bgtr_cfg_t   cfg,
    input  wire bgtr_pkg::bgtr_cmd_t   cmd,
    output bgtr_pkg::bgtr_sts_t        sts,
    input  wire logic                  in_cmd,
    input  wire logic [10:0]           in_font_address,
    input  wire logic [7:0]            in_font_byte,
    input  wire logic [7:0]            in_char_code,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 out_op,
    output logic [10:0]                out_x_start,
    output logic [11:0]                out_y_start,
    output logic [10:0]                out_x_end,
    output logic [11:0]                out_y_end,
    output logic [10:0]                out_cursor_x,
    output logic [11:0]                out_cursor_y,
    output logic                       out_last
);

    localparam int AW  = $clog2(FONT_DEPTH);
    localparam int WAW = ((AW > 11) ? AW : 11) + 1;
    localparam int BW  = 13;

    // Font store.
    logic [7:0]    mem [FONT_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          wr_ok;

    // Cursor and glyph origin.
    logic [10:0]   cx_reg;
    logic [11:0]   cy_reg;
    logic [10:0]   ox_reg;
    logic [11:0]   oy_reg;

    // Glyph walk.
    logic [BW-1:0] addr_reg;
    logic [BW-1:0] addr_inc;
    logic [3:0]    bcnt_reg;
    logic [2:0]    bit_reg;
    logic [3:0]    gx_reg;
    logic [5:0]    gy_reg;

    // Held result and output register.
    logic          pend_valid_reg;
    logic [1:0]    pend_op_reg;
    logic [10:0]   pend_xs_reg;
    logic [11:0]   pend_ys_reg;
    logic [10:0]   pend_xe_reg;
    logic [11:0]   pend_ye_reg;
    logic          out_valid_reg;
    logic [1:0]    out_op_reg;
    logic [10:0]   out_xs_reg;
    logic [11:0]   out_ys_reg;
    logic [10:0]   out_xe_reg;
    logic [11:0]   out_ye_reg;
    logic [10:0]   out_cx_reg;
    logic [11:0]   out_cy_reg;
    logic          out_last_reg;

    // Derived sizes.
    logic [3:0]    s_eff;
    logic [7:0]    wsz;
    logic [8:0]    hsz;
    logic [8:0]    adv;
    logic [9:0]    line_step;
    logic [3:0]    nb;

    // Cursor moves.
    logic [13:0]   nl_cy_sum;
    logic [11:0]   nl_cy;
    logic          wrap;
    logic [10:0]   g_ox;
    logic [11:0]   g_oy;
    logic [10:0]   bs_cx;
    logic [11:0]   bs_cy;

    // Draw coordinates for the current bit.
    logic [7:0]    gxs;
    logic [9:0]    gys;
    logic [13:0]   bx;
    logic [13:0]   by;
    logic [10:0]   n_xs;
    logic [11:0]   n_ys;
    logic [10:0]   n_xe;
    logic [11:0]   n_ye;
    logic [1:0]    n_op;
    logic          bit_set;
    logic          out_free;
    logic          load_out;
    logic          load_last;

    always_comb
    begin
        s_eff     = (cfg.scale == 4'd0) ? 4'd1 : cfg.scale;
        wsz       = 8'(cfg.glyph_width) * 8'(s_eff);
        hsz       = 9'(cfg.glyph_height) * 9'(s_eff);
        adv       = 9'(wsz) + 9'(cfg.spacing);
        line_step = 10'(hsz) + 10'(cfg.spacing);
        nb        = (cfg.glyph_bytes > bgtr_pkg::MAX_WALK_BYTES) ?
                    bgtr_pkg::MAX_WALK_BYTES : cfg.glyph_bytes;

        nl_cy_sum = 14'(cy_reg) + 14'(line_step);
        nl_cy     = bgtr_pkg::clamp_y(nl_cy_sum);
        wrap      = (12'(cx_reg) + 12'(adv)) > 12'(LINE_LIMIT);
        g_ox      = wrap ? 11'(cfg.left_margin) : cx_reg;
        g_oy      = wrap ? nl_cy : cy_reg;

        bs_cx     = (cx_reg > 11'(adv)) ? (cx_reg - 11'(adv)) : 11'd0;
        bs_cy     = (cy_reg > 12'(line_step)) ? (cy_reg - 12'(line_step)) : 12'd0;

        gxs       = 8'(gx_reg) * 8'(s_eff);
        gys       = 10'(gy_reg) * 10'(s_eff);
        bx        = 14'(ox_reg) + 14'(gxs);
        by        = 14'(oy_reg) + 14'(gys);
        n_xs      = bgtr_pkg::clamp_x(bx);
        n_ys      = bgtr_pkg::clamp_y(by);
        if (s_eff <= 4'd1)
        begin
            n_op = bgtr_pkg::OP_SET_PIXEL;
            n_xe = n_xs;
            n_ye = n_ys;
        end
        else
        begin
            n_op = bgtr_pkg::OP_FILL_BOX;
            n_xe = bgtr_pkg::clamp_x(bx + 14'(s_eff));
            n_ye = bgtr_pkg::clamp_y(by + 14'(s_eff));
        end

        bit_set   = rd_data_reg[3'd7 - bit_reg];
        out_free  = !out_valid_reg || out_ready;
        load_out  = (cmd.bit_step && bit_set && pend_valid_reg) ||
                    (cmd.flush && pend_valid_reg);
        load_last = cmd.flush;
        addr_inc  = (addr_reg + BW'(1) == BW'(FONT_DEPTH)) ? '0 : addr_reg + BW'(1);
        wr_ok     = WAW'(in_font_address) < WAW'(FONT_DEPTH);
    end

    always_comb
    begin
        sts.is_write      = (in_cmd == bgtr_pkg::CMD_FONT_WRITE);
        sts.is_newline    = (in_char_code == bgtr_pkg::CHAR_NEWLINE);
        sts.is_bs         = (in_char_code == bgtr_pkg::CHAR_BACKSPACE);
        sts.at_left_edge  = (cx_reg == 11'd0);
        sts.base_ge_depth = addr_reg >= BW'(FONT_DEPTH);
        sts.nb_zero       = (nb == 4'd0);
        sts.bit_set       = bit_set;
        sts.last_bit      = (bit_reg == 3'd7);
        sts.last_byte     = (bcnt_reg + 4'd1 == nb);
        sts.pend_valid    = pend_valid_reg;
        sts.out_free      = out_free;
    end

    // Font store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.font_wr && wr_ok)
        begin
            mem[AW'(in_font_address)] <= in_font_byte;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[addr_reg[AW-1:0]];
        end
    end

    // Cursor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= 12'(START_ROW);
        end
        else if (cmd.newline)
        begin
            cx_reg <= 11'(cfg.left_margin);
            cy_reg <= nl_cy;
        end
        else if (cmd.bs_edge)
        begin
            cx_reg <= 11'(LINE_LIMIT);
            cy_reg <= bs_cy;
        end
        else if (cmd.bs_box)
        begin
            cx_reg <= bs_cx;
        end
        else if (cmd.glyph_start)
        begin
            cx_reg <= bgtr_pkg::clamp_x(14'(g_ox) + 14'(adv));
            cy_reg <= g_oy;
        end
    end

    // Walk counters and glyph origin.
    always_ff @(posedge clk)
    begin
        if (cmd.glyph_start)
        begin
            ox_reg   <= g_ox;
            oy_reg   <= g_oy;
            addr_reg <= BW'(cfg.glyph_bytes) * BW'(in_char_code);
            bcnt_reg <= '0;
            bit_reg  <= '0;
            gx_reg   <= '0;
            gy_reg   <= '0;
        end
        else if (cmd.reduce)
        begin
            addr_reg <= addr_reg - BW'(FONT_DEPTH);
        end
        else if (cmd.bit_step)
        begin
            bit_reg <= bit_reg + 3'd1;
            // The walk wraps to the next glyph row every glyph_width bits.
            if (5'(gx_reg) + 5'd1 < 5'(cfg.glyph_width))
            begin
                gx_reg <= gx_reg + 4'd1;
            end
            else
            begin
                gx_reg <= '0;
                gy_reg <= gy_reg + 6'd1;
            end
            if (bit_reg == 3'd7)
            begin
                bcnt_reg <= bcnt_reg + 4'd1;
                addr_reg <= addr_inc;
            end
        end
    end

    // Held result: one set bit is kept back so the final one can carry last.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.bs_box || (cmd.bit_step && bit_set))
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (cmd.flush)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.bs_box)
        begin
            pend_op_reg <= bgtr_pkg::OP_CLEAR_BOX;
            pend_xs_reg <= bs_cx;
            pend_ys_reg <= cy_reg;
            pend_xe_reg <= bgtr_pkg::clamp_x(14'(bs_cx) + 14'(wsz));
            pend_ye_reg <= bgtr_pkg::clamp_y(14'(cy_reg) + 14'(hsz));
        end
        else if (cmd.bit_step && bit_set)
        begin
            pend_op_reg <= n_op;
            pend_xs_reg <= n_xs;
            pend_ys_reg <= n_ys;
            pend_xe_reg <= n_xe;
            pend_ye_reg <= n_ye;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_op_reg   <= pend_op_reg;
            out_xs_reg   <= pend_xs_reg;
            out_ys_reg   <= pend_ys_reg;
            out_xe_reg   <= pend_xe_reg;
            out_ye_reg   <= pend_ye_reg;
            out_cx_reg   <= cx_reg;
            out_cy_reg   <= cy_reg;
            out_last_reg <= load_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_op       = out_op_reg;
    assign out_x_start  = out_xs_reg;
    assign out_y_start  = out_ys_reg;
    assign out_x_end    = out_xe_reg;
    assign out_y_end    = out_ye_reg;
    assign out_cursor_x = out_cx_reg;
    assign out_cursor_y = out_cy_reg;
    assign out_last     = out_last_reg;

    // The output stage is only loaded when it has room.
    a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free)
        else $error("output register overwritten");

    // Font reads always land inside the store.
    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (addr_reg < BW'(FONT_DEPTH)))
        else $error("font read out of range");

    // A waiting draw command stays put until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=>
        (out_valid_reg && $stable(out_op_reg) && $stable(out_last_reg)))
        else $error("waiting draw command changed");

    // A new item starts with no held result.
    a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.glyph_start || cmd.bs_box) |-> !pend_valid_reg)
        else $error("stale held result at item start");

endmodule

`default_nettype wire

@@ sv/bitmap_glyph_text_renderer.sv @@
// Top level of the bitmap glyph text renderer: configuration registers,
// controller and datapath. Depends on bgtr_pkg, bgtr_ctrl and bgtr_datapath.
//
//   Channel   Direction  Handshake                  Contents
//   s_axis    in         s_axis_tvalid/tready       font write or character code
//   m_axis    out        m_axis_tvalid/tready       pixel or box draw command
//   cfg       in         cfg_we (no wait)           six layout registers
//
// A font write, a newline and a backspace at the left edge are taken without leaving the idle state.
// A backspace elsewhere loads a clear box, then waits in the flush state until the output register has room.
// A glyph is walked in steps: R subtractions bring glyph_bytes*code
// below FONT_DEPTH (one per cycle), then each of the B bytes (at most eight)
// costs one font store read and eight bit steps, one draw command at most
// per cycle. A full output register stalls the bit walk on a set bit.
// Reset puts the cursor at column 0 of START_ROW, sets the registers to their
// reset values and clears all handshake state; the font store is not cleared and must be written before it is read.
`default_nettype none

module bitmap_glyph_text_renderer #(
    parameter int LINE_LIMIT = 1024,
    parameter int FONT_DEPTH = 2048,
    parameter int START_ROW  = 58
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input items.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // font_address, font_byte, char_code, zero pad
    input  wire logic        s_axis_tuser,   // cmd
    // Draw commands.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // x_start, y_start, x_end, y_end,
                                             // cursor_x_out, cursor_y_out, zero pad
    output logic [1:0]       m_axis_tuser,   // op
    output logic             m_axis_tlast,   // last
    // Configuration writes.
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [9:0]  cfg_data
);

    bgtr_pkg::bgtr_cfg_t cfg_reg;
    bgtr_pkg::bgtr_cmd_t cmd;
    bgtr_pkg::bgtr_sts_t sts;

    logic [10:0] x_start;
    logic [11:0] y_start;
    logic [10:0] x_end;
    logic [11:0] y_end;
    logic [10:0] cursor_x_out;
    logic [11:0] cursor_y_out;

    // Configuration registers; writes to an index beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glyph_width  <= bgtr_pkg::RST_GLYPH_WIDTH;
            cfg_reg.glyph_height <= bgtr_pkg::RST_GLYPH_HEIGHT;
            cfg_reg.glyph_bytes  <= bgtr_pkg::RST_GLYPH_BYTES;
            cfg_reg.scale        <= bgtr_pkg::RST_SCALE;
            cfg_reg.spacing      <= bgtr_pkg::RST_SPACING;
            cfg_reg.left_margin  <= bgtr_pkg::RST_LEFT_MARGIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bgtr_pkg::REG_GLYPH_WIDTH:  cfg_reg.glyph_width  <= cfg_data[3:0];
                bgtr_pkg::REG_GLYPH_HEIGHT: cfg_reg.glyph_height <= cfg_data[4:0];
                bgtr_pkg::REG_GLYPH_BYTES:  cfg_reg.glyph_bytes  <= cfg_data[3:0];
                bgtr_pkg::REG_SCALE:        cfg_reg.scale        <= cfg_data[3:0];
                bgtr_pkg::REG_SPACING:      cfg_reg.spacing      <= cfg_data[3:0];
                bgtr_pkg::REG_LEFT_MARGIN:  cfg_reg.left_margin  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The controller sequences each item; it sees only status from the datapath.
    bgtr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bgtr_datapath #(
        .LINE_LIMIT (LINE_LIMIT),
        .FONT_DEPTH (FONT_DEPTH),
        .START_ROW  (START_ROW)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .sts             (sts),
        .in_cmd          (s_axis_tuser),
        .in_font_address (s_axis_tdata[10:0]),
        .in_font_byte    (s_axis_tdata[18:11]),
        .in_char_code    (s_axis_tdata[26:19]),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_op          (m_axis_tuser),
        .out_x_start     (x_start),
        .out_y_start     (y_start),
        .out_x_end       (x_end),
        .out_y_end       (y_end),
        .out_cursor_x    (cursor_x_out),
        .out_cursor_y    (cursor_y_out),
        .out_last        (m_axis_tlast)
    );

    // Pack the draw command, first field in the lowest bits.
    assign m_axis_tdata = {3'd0, cursor_y_out, cursor_x_out, y_end, x_end, y_start, x_start};

endmodule

`default_nettype wire
